/* rtl/udp_ipv4_ethernet_encapsulator_macros.svh */
// ---------------------------------------------------------------------------
// UDP/IPv4/Ethernet encapsulator assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef UDP_IPV4_ETHERNET_ENCAPSULATOR_MACROS_SVH
`define UDP_IPV4_ETHERNET_ENCAPSULATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define UIE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uie assertion failed");
// next-cycle implication
`define UIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uie assertion failed");
`else
`define UIE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define UIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/uie_pkg.sv */
// ---------------------------------------------------------------------------
// uie_pkg
// Shared types, constants and the one's-complement add for the encapsulator.
// ---------------------------------------------------------------------------
package uie_pkg;

    localparam int unsigned SUM_W       = 16;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned ACC_W       = 20;  // ten 16-bit terms
    localparam int unsigned HDR_BYTES   = 42;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned SUM_STEPS   = 10;
    localparam int unsigned STEP_W      = 4;
    localparam int unsigned MAX_PAYLOAD_DEF = 65507;
    localparam int unsigned JOBQ_DEPTH_DEF  = 2;
    localparam int unsigned APB_ADDR_W  = 6;
    localparam int unsigned APB_DATA_W  = 64;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] IP_VER_TOS     = 16'h4510;
    localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
    localparam logic [7:0]  UDP_PROTOCOL_NUM = 8'd17;
    localparam logic [COUNT_W-1:0] IP_LEN_ADD  = 17'd28;
    localparam logic [COUNT_W-1:0] UDP_LEN_ADD = 17'd8;

    localparam logic [7:0] TTL_RESET = 8'd64;

    // register indexes
    localparam logic [2:0] REG_SOURCE_MAC       = 3'd0;
    localparam logic [2:0] REG_DESTINATION_MAC  = 3'd1;
    localparam logic [2:0] REG_SOURCE_IP        = 3'd2;
    localparam logic [2:0] REG_DESTINATION_IP   = 3'd3;
    localparam logic [2:0] REG_SOURCE_PORT      = 3'd4;
    localparam logic [2:0] REG_DESTINATION_PORT = 3'd5;
    localparam logic [2:0] REG_TIME_TO_LIVE     = 3'd6;
    localparam logic [2:0] REG_UDP_SUM_ENABLE   = 3'd7;

    typedef struct packed {
        logic [47:0] source_mac;
        logic [47:0] destination_mac;
        logic [31:0] source_ip;
        logic [31:0] destination_ip;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  time_to_live;
        logic        udp_sum_enable;
    } t_cfg;

    // one finished payload, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_job;

    function automatic logic [SUM_W-1:0] ones_add16(input logic [SUM_W-1:0] a,
                                                    input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
    endfunction

endpackage

/* rtl/uie_front.sv */
// ---------------------------------------------------------------------------
// uie_front
// Takes payload items, keeps byte count and running sum, posts a job on last.
// ---------------------------------------------------------------------------
module uie_front #(
    parameter int unsigned MAX_PAYLOAD = uie_pkg::MAX_PAYLOAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_present,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output uie_pkg::t_job o_job
);

    logic [uie_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [uie_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_odd, n_odd;
    logic                        r_ovf, n_ovf;
    logic                        w_accept;
    logic [uie_pkg::SUM_W-1:0]   w_word;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_word   = r_odd ? {8'd0, i_byte} : {i_byte, 8'd0};

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_odd   = r_odd;
        n_ovf   = r_ovf;
        if (i_present) begin
            n_sum = uie_pkg::ones_add16(r_sum, w_word);
            n_odd = !r_odd;
            if (r_count != uie_pkg::COUNT_SAT) begin
                n_count = r_count + 1'b1;
            end
            if (n_count > uie_pkg::COUNT_W'(MAX_PAYLOAD)) begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_push         = w_accept && i_last;
    assign o_job.sum      = n_sum;
    assign o_job.count    = n_count;
    assign o_job.overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_odd   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_sum   <= '0;
                r_count <= '0;
                r_odd   <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_odd   <= n_odd;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

/* rtl/uie_jobq.sv */
// ---------------------------------------------------------------------------
// uie_jobq
// Small FIFO of finished payload jobs between front and back.
// ---------------------------------------------------------------------------
`include "udp_ipv4_ethernet_encapsulator_macros.svh"

module uie_jobq #(
    parameter int unsigned DEPTH = uie_pkg::JOBQ_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uie_pkg::t_job i_job,
    input  logic          i_pop,
    output uie_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    uie_pkg::t_job    r_mem [DEPTH];
    uie_pkg::t_job    r_head;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_job   = r_head;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        // head after this edge; bypass when the new item lands there
        if (i_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_job;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    `UIE_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `UIE_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `UIE_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop && o_empty, r_count == CNT_W'(1))

endmodule

/* rtl/uie_back.sv */
// ---------------------------------------------------------------------------
// uie_back
// Sums header checksums one term a cycle, then streams the 42 header bytes.
// ---------------------------------------------------------------------------
`include "udp_ipv4_ethernet_encapsulator_macros.svh"

module uie_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uie_pkg::t_cfg i_cfg,
    input  uie_pkg::t_job i_job,
    input  logic          i_q_empty,
    input  logic          i_m_tready,
    output logic          o_pop,
    output logic          o_m_tvalid,
    output logic [7:0]    o_m_tdata,
    output logic          o_m_tlast,
    output logic          o_m_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [uie_pkg::STEP_W-1:0] LAST_STEP =
        uie_pkg::STEP_W'(uie_pkg::SUM_STEPS - 1);
    localparam logic [uie_pkg::IDX_W-1:0] LAST_IDX =
        uie_pkg::IDX_W'(uie_pkg::HDR_BYTES - 1);

    logic [1:0]                  r_state, n_state;
    logic [uie_pkg::STEP_W-1:0]  r_step, n_step;
    logic [uie_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_out_valid, n_out_valid;

    logic [uie_pkg::ACC_W-1:0]   r_ip_acc, r_udp_acc;
    logic [15:0]                 r_ip_len, r_udp_len;
    logic [uie_pkg::SUM_W-1:0]   r_psum;
    logic                        r_ovf;
    logic [15:0]                 r_ip_ck, r_udp_ck;
    logic [7:0]                  r_out_byte;
    logic                        r_out_last, r_out_err;

    logic [15:0]                 w_ip_term, w_udp_term;
    logic [16:0]                 w_ip_f1, w_udp_f1;
    logic [15:0]                 w_ip_f2, w_udp_f2;
    logic [15:0]                 w_udp_ck;
    logic [7:0]                  w_hdr_byte;
    logic                        w_out_free;
    logic                        w_load;
    logic [uie_pkg::COUNT_W-1:0] w_ip_len17, w_udp_len17;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_load     = (r_state == ST_EMIT) && w_out_free;
    assign o_pop      = (r_state == ST_IDLE) && !i_q_empty;

    assign w_ip_len17  = i_job.count + uie_pkg::IP_LEN_ADD;
    assign w_udp_len17 = i_job.count + uie_pkg::UDP_LEN_ADD;

    // one term of each checksum per step
    always_comb begin
        case (r_step)
            4'd0: begin
                w_ip_term  = uie_pkg::IP_VER_TOS;
                w_udp_term = {8'd0, uie_pkg::UDP_PROTOCOL_NUM};
            end
            4'd1: begin
                w_ip_term  = r_ip_len;
                w_udp_term = r_udp_len;
            end
            4'd2: begin
                w_ip_term  = uie_pkg::IP_FLAGS_DF;
                w_udp_term = r_psum;
            end
            4'd3: begin
                w_ip_term  = {i_cfg.time_to_live, uie_pkg::UDP_PROTOCOL_NUM};
                w_udp_term = i_cfg.source_port;
            end
            4'd4: begin
                w_ip_term  = i_cfg.source_ip[31:16];
                w_udp_term = i_cfg.source_ip[31:16];
            end
            4'd5: begin
                w_ip_term  = i_cfg.source_ip[15:0];
                w_udp_term = i_cfg.source_ip[15:0];
            end
            4'd6: begin
                w_ip_term  = i_cfg.destination_ip[31:16];
                w_udp_term = i_cfg.destination_ip[31:16];
            end
            4'd7: begin
                w_ip_term  = i_cfg.destination_ip[15:0];
                w_udp_term = i_cfg.destination_ip[15:0];
            end
            4'd8: begin
                w_ip_term  = 16'd0;
                w_udp_term = i_cfg.destination_port;
            end
            4'd9: begin
                w_ip_term  = 16'd0;
                w_udp_term = r_udp_len;
            end
            default: begin
                w_ip_term  = 16'd0;
                w_udp_term = 16'd0;
            end
        endcase
    end

    // end-around carry fold; order of terms does not change the result
    assign w_ip_f1  = {1'b0, r_ip_acc[15:0]} + {13'd0, r_ip_acc[19:16]};
    assign w_ip_f2  = w_ip_f1[15:0] + {15'd0, w_ip_f1[16]};
    assign w_udp_f1 = {1'b0, r_udp_acc[15:0]} + {13'd0, r_udp_acc[19:16]};
    assign w_udp_f2 = w_udp_f1[15:0] + {15'd0, w_udp_f1[16]};

    always_comb begin
        w_udp_ck = ~w_udp_f2;
        if (w_udp_ck == 16'd0) begin
            w_udp_ck = 16'hFFFF;
        end
        if (!i_cfg.udp_sum_enable) begin
            w_udp_ck = 16'd0;
        end
    end

    always_comb begin
        case (r_idx)
            6'd0:  w_hdr_byte = i_cfg.destination_mac[47:40];
            6'd1:  w_hdr_byte = i_cfg.destination_mac[39:32];
            6'd2:  w_hdr_byte = i_cfg.destination_mac[31:24];
            6'd3:  w_hdr_byte = i_cfg.destination_mac[23:16];
            6'd4:  w_hdr_byte = i_cfg.destination_mac[15:8];
            6'd5:  w_hdr_byte = i_cfg.destination_mac[7:0];
            6'd6:  w_hdr_byte = i_cfg.source_mac[47:40];
            6'd7:  w_hdr_byte = i_cfg.source_mac[39:32];
            6'd8:  w_hdr_byte = i_cfg.source_mac[31:24];
            6'd9:  w_hdr_byte = i_cfg.source_mac[23:16];
            6'd10: w_hdr_byte = i_cfg.source_mac[15:8];
            6'd11: w_hdr_byte = i_cfg.source_mac[7:0];
            6'd12: w_hdr_byte = uie_pkg::ETHERTYPE_IPV4[15:8];
            6'd13: w_hdr_byte = uie_pkg::ETHERTYPE_IPV4[7:0];
            6'd14: w_hdr_byte = uie_pkg::IP_VER_TOS[15:8];
            6'd15: w_hdr_byte = uie_pkg::IP_VER_TOS[7:0];
            6'd16: w_hdr_byte = r_ip_len[15:8];
            6'd17: w_hdr_byte = r_ip_len[7:0];
            6'd20: w_hdr_byte = uie_pkg::IP_FLAGS_DF[15:8];
            6'd21: w_hdr_byte = uie_pkg::IP_FLAGS_DF[7:0];
            6'd22: w_hdr_byte = i_cfg.time_to_live;
            6'd23: w_hdr_byte = uie_pkg::UDP_PROTOCOL_NUM;
            6'd24: w_hdr_byte = r_ip_ck[15:8];
            6'd25: w_hdr_byte = r_ip_ck[7:0];
            6'd26: w_hdr_byte = i_cfg.source_ip[31:24];
            6'd27: w_hdr_byte = i_cfg.source_ip[23:16];
            6'd28: w_hdr_byte = i_cfg.source_ip[15:8];
            6'd29: w_hdr_byte = i_cfg.source_ip[7:0];
            6'd30: w_hdr_byte = i_cfg.destination_ip[31:24];
            6'd31: w_hdr_byte = i_cfg.destination_ip[23:16];
            6'd32: w_hdr_byte = i_cfg.destination_ip[15:8];
            6'd33: w_hdr_byte = i_cfg.destination_ip[7:0];
            6'd34: w_hdr_byte = i_cfg.source_port[15:8];
            6'd35: w_hdr_byte = i_cfg.source_port[7:0];
            6'd36: w_hdr_byte = i_cfg.destination_port[15:8];
            6'd37: w_hdr_byte = i_cfg.destination_port[7:0];
            6'd38: w_hdr_byte = r_udp_len[15:8];
            6'd39: w_hdr_byte = r_udp_len[7:0];
            6'd40: w_hdr_byte = r_udp_ck[15:8];
            6'd41: w_hdr_byte = r_udp_ck[7:0];
            default: w_hdr_byte = 8'd0;  // ident and unused bytes
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_SUM;
                    n_step  = '0;
                end
            end
            ST_SUM: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_state = ST_EMIT;
                n_idx   = '0;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_psum    <= i_job.sum;
            r_ovf     <= i_job.overflow;
            r_ip_len  <= w_ip_len17[15:0];
            r_udp_len <= w_udp_len17[15:0];
            r_ip_acc  <= '0;
            r_udp_acc <= '0;
        end else if (r_state == ST_SUM) begin
            r_ip_acc  <= r_ip_acc + {4'd0, w_ip_term};
            r_udp_acc <= r_udp_acc + {4'd0, w_udp_term};
        end
        if (r_state == ST_FOLD) begin
            r_ip_ck  <= ~w_ip_f2;
            r_udp_ck <= w_udp_ck;
        end
        if (w_load) begin
            r_out_byte <= w_hdr_byte;
            r_out_last <= (r_idx == LAST_IDX);
            r_out_err  <= r_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

    `UIE_ASSERT_NEXT(a_sum_to_fold, i_clk, i_rst_n, r_state == ST_SUM && r_step == LAST_STEP, r_state == ST_FOLD)
    `UIE_ASSERT_NEXT(a_fold_to_emit, i_clk, i_rst_n, r_state == ST_FOLD, r_state == ST_EMIT && r_idx == '0)
    `UIE_ASSERT_NEXT(a_last_byte, i_clk, i_rst_n, w_load && r_idx == LAST_IDX, r_state == ST_IDLE && o_m_tvalid && o_m_tlast)

endmodule

/* rtl/udp_ipv4_ethernet_encapsulator.sv */
// ---------------------------------------------------------------------------
// udp_ipv4_ethernet_encapsulator
// Counts and sums a UDP payload, then emits its Ethernet/IPv4/UDP header.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake            tdata / tuser / tlast
//  -------   ---  -------------------  -----------------------------------------
//  s (in)    in   i_s_tvalid/o_s_tready payload_byte / byte_present / end_of_payload
//  m (out)   out  o_m_tvalid/i_m_tready header_byte / length_error / header_last
//  apb       in   psel+penable+pwrite  8 regs, 64-bit data at 8*index
//
//  Input side takes one item per cycle; tready drops only while the job
//  queue (JOBQ_DEPTH finished payloads) is full.
//  For each header the back end pops the job, sums the checksum terms
//  one per cycle, folds them, then streams the 42 header bytes
//  (one per cycle while i_m_tready is high).
//  Output is a single register stage; a stall holds it, the back end waits.
//  Reset (i_rst_n low, synchronous) clears counters, queue and FSM, and
//  loads the register defaults (TTL 64, UDP checksum on).
//
module udp_ipv4_ethernet_encapsulator #(
    parameter int unsigned MAX_PAYLOAD = uie_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned JOBQ_DEPTH  = uie_pkg::JOBQ_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // payload in
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] payload_byte
    input  logic                           i_s_tuser,   // [0] byte_present
    input  logic                           i_s_tlast,
    // header out
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,   // [7:0] header_byte
    output logic                           o_m_tuser,   // [0] length_error
    output logic                           o_m_tlast,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [uie_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [uie_pkg::APB_DATA_W-1:0] pwdata,
    output logic [uie_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    uie_pkg::t_cfg r_cfg;
    logic          w_cfg_wr;
    logic [2:0]    w_reg_idx;

    logic          w_q_full, w_q_empty;
    logic          w_push, w_pop;
    uie_pkg::t_job w_job_in, w_job_out;

    // ---- registers --------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_mac       <= '0;
            r_cfg.destination_mac  <= '0;
            r_cfg.source_ip        <= '0;
            r_cfg.destination_ip   <= '0;
            r_cfg.source_port      <= '0;
            r_cfg.destination_port <= '0;
            r_cfg.time_to_live     <= uie_pkg::TTL_RESET;
            r_cfg.udp_sum_enable   <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                uie_pkg::REG_SOURCE_MAC:       r_cfg.source_mac       <= pwdata[47:0];
                uie_pkg::REG_DESTINATION_MAC:  r_cfg.destination_mac  <= pwdata[47:0];
                uie_pkg::REG_SOURCE_IP:        r_cfg.source_ip        <= pwdata[31:0];
                uie_pkg::REG_DESTINATION_IP:   r_cfg.destination_ip   <= pwdata[31:0];
                uie_pkg::REG_SOURCE_PORT:      r_cfg.source_port      <= pwdata[15:0];
                uie_pkg::REG_DESTINATION_PORT: r_cfg.destination_port <= pwdata[15:0];
                uie_pkg::REG_TIME_TO_LIVE:     r_cfg.time_to_live     <= pwdata[7:0];
                uie_pkg::REG_UDP_SUM_ENABLE:   r_cfg.udp_sum_enable   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            uie_pkg::REG_SOURCE_MAC:       prdata = {16'd0, r_cfg.source_mac};
            uie_pkg::REG_DESTINATION_MAC:  prdata = {16'd0, r_cfg.destination_mac};
            uie_pkg::REG_SOURCE_IP:        prdata = {32'd0, r_cfg.source_ip};
            uie_pkg::REG_DESTINATION_IP:   prdata = {32'd0, r_cfg.destination_ip};
            uie_pkg::REG_SOURCE_PORT:      prdata = {48'd0, r_cfg.source_port};
            uie_pkg::REG_DESTINATION_PORT: prdata = {48'd0, r_cfg.destination_port};
            uie_pkg::REG_TIME_TO_LIVE:     prdata = {56'd0, r_cfg.time_to_live};
            uie_pkg::REG_UDP_SUM_ENABLE:   prdata = {63'd0, r_cfg.udp_sum_enable};
            default:                       prdata = '0;
        endcase
    end

    // ---- front: count and sum payload bytes --------------------------------
    uie_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_byte    (i_s_tdata),
        .i_present (i_s_tuser),
        .i_last    (i_s_tlast),
        .i_q_full  (w_q_full),
        .o_ready   (o_s_tready),
        .o_push    (w_push),
        .o_job     (w_job_in)
    );

    // ---- job queue: lets front and back stall independently ----------------
    uie_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // ---- back: checksums and header byte stream ----------------------------
    uie_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job      (w_job_out),
        .i_q_empty  (w_q_empty),
        .i_m_tready (i_m_tready),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
